// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the sequencer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define BCS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define BCS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/bcs_pkg.sv =====
`default_nettype none

package bcs_pkg;

  // Most words one tick can produce.
  localparam int unsigned MaxResults = 3;

  // Sensor registers and commands.
  localparam logic [7:0] SENSOR_REG_CTRL = 8'hF4;
  localparam logic [7:0] SENSOR_REG_DATA = 8'hF6;
  localparam logic [7:0] CMD_TEMP_START  = 8'h2E;
  localparam logic [7:0] CMD_PRES_START  = 8'h34;

  // Bus read lengths in bytes.
  localparam logic [1:0] TEMP_READ_LEN = 2'd2;
  localparam logic [1:0] PRES_READ_LEN = 2'd3;

  // Conversion waits in milliseconds.
  localparam logic [4:0] TEMP_WAIT_MS = 5'd5;

  typedef enum logic [1:0] {
    KIND_BUS_WRITE   = 2'd0,
    KIND_BUS_READ    = 2'd1,
    KIND_TEMP_SAMPLE = 2'd2,
    KIND_PRES_SAMPLE = 2'd3
  } bcs_kind_e;

  typedef enum logic [1:0] {
    PH_START_TEMP = 2'd0,
    PH_READ_TEMP  = 2'd1,
    PH_START_PRES = 2'd2,
    PH_READ_PRES  = 2'd3
  } bcs_phase_e;

  typedef enum logic [1:0] {
    WAIT_NONE = 2'd0,
    WAIT_TEMP = 2'd1,
    WAIT_PRES = 2'd2
  } bcs_wait_e;

  // One result word.
  typedef struct packed {
    bcs_kind_e   kind;
    logic [7:0]  reg_addr;
    logic [7:0]  write_byte;
    logic [1:0]  read_len;
    logic [18:0] sample;
    logic        last;
  } bcs_result_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [1:0] oversampling;
    logic       enable;
  } bcs_cfg_t;

  // Pending tick handed from the core to the output buffer.
  typedef struct packed {
    logic       valid;
    logic [1:0] count;
  } bcs_batch_t;

  // Pressure conversion time per oversampling setting.
  function automatic logic [4:0] bcs_pres_wait(input logic [1:0] oss);
    logic [4:0] w;
    case (oss)
      2'd0:    w = 5'd5;
      2'd1:    w = 5'd8;
      2'd2:    w = 5'd14;
      default: w = 5'd26;
    endcase
    return w;
  endfunction

  function automatic bcs_result_t bcs_bus_write(input logic [7:0] data);
    bcs_result_t r;
    r            = '0;
    r.kind       = KIND_BUS_WRITE;
    r.reg_addr   = SENSOR_REG_CTRL;
    r.write_byte = data;
    return r;
  endfunction

  function automatic bcs_result_t bcs_bus_read(input logic [1:0] len);
    bcs_result_t r;
    r          = '0;
    r.kind     = KIND_BUS_READ;
    r.reg_addr = SENSOR_REG_DATA;
    r.read_len = len;
    return r;
  endfunction

  function automatic bcs_result_t bcs_sample(input bcs_kind_e k, input logic [18:0] value);
    bcs_result_t r;
    r        = '0;
    r.kind   = k;
    r.sample = value;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/barometer_conversion_sequencer.sv =====
// Barometer conversion sequencer. Each word on the input stream is one
// millisecond tick carrying the three bytes read from the sensor data register
// and a read-success flag in tuser. The block steps a pressure sensor through
// start-temperature, read-temperature, start-pressure and read-pressure, and
// for each tick emits zero to three words: bus write requests, bus read
// requests and raw temperature or shifted pressure samples, with tuser giving
// the kind and tlast marking the final word of the tick. A tick is taken into
// the input register in one cycle and its words are computed in the next; the
// output buffer then sends one word per cycle while the result stream is ready,
// and the next tick is taken while the previous one's words drain. The
// oversampling (address 0, reset 2) and enable (address 4, reset 1) registers
// must be written over the APB port only while the stream is idle; the block
// itself does not enforce this.
`default_nettype none

module barometer_conversion_sequencer
  import bcs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // Tick stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // [23:0] sensor_bytes
  input  wire logic        s_axis_tuser,   // [0] read_ok
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [7:0] reg_addr, [15:8] write_byte,
                                           // [17:16] read_len, [36:18] sample, [39:37] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast
);

  bcs_cfg_t                    cfg;
  bcs_batch_t                  batch;
  bcs_result_t [MaxResults-1:0] results;
  bcs_result_t                 word;
  logic                        take;

  bcs_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bcs_phase_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .tick_valid_i   (s_axis_tvalid),
    .tick_ready_o   (s_axis_tready),
    .sensor_bytes_i (s_axis_tdata),
    .read_ok_i      (s_axis_tuser),
    .take_i         (take),
    .batch_o        (batch),
    .results_o      (results)
  );

  bcs_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .batch_i     (batch),
    .results_i   (results),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_word_o  (word)
  );

  // Pack the result word onto the stream.
  assign m_axis_tdata = {3'd0, word.sample, word.read_len, word.write_byte, word.reg_addr};
  assign m_axis_tuser = word.kind;
  assign m_axis_tlast = word.last;

endmodule

`default_nettype wire

// ===== sv/bcs_cfg_regs.sv =====
`default_nettype none

module bcs_cfg_regs
  import bcs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output bcs_cfg_t         cfg_o
);

  // Register select: address bit 2 picks the register.
  localparam logic REG_SEL_OSS = 1'b0;
  localparam logic REG_SEL_EN  = 1'b1;

  logic [1:0] oss_q, oss_d;
  logic       en_q, en_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write decode.
  always_comb begin
    oss_d = oss_q;
    en_d  = en_q;
    if (wr_en) begin
      unique case (paddr[2])
        REG_SEL_OSS: oss_d = pwdata[1:0];
        REG_SEL_EN:  en_d  = pwdata[0];
        default:     oss_d = oss_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oss_q <= 2'd2;
      en_q  <= 1'b1;
    end else begin
      oss_q <= oss_d;
      en_q  <= en_d;
    end
  end

  // Read decode.
  always_comb begin
    unique case (paddr[2])
      REG_SEL_OSS: prdata = {30'd0, oss_q};
      REG_SEL_EN:  prdata = {31'd0, en_q};
      default:     prdata = '0;
    endcase
  end

  assign cfg_o.oversampling = oss_q;
  assign cfg_o.enable       = en_q;

endmodule

`default_nettype wire

// ===== sv/bcs_phase_core.sv =====
`default_nettype none

`include "assert_macros.svh"

module bcs_phase_core
  import bcs_pkg::*;
(
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bcs_cfg_t                       cfg_i,
  input  wire logic                           tick_valid_i,
  output logic                                tick_ready_o,
  input  wire logic [23:0]                    sensor_bytes_i,
  input  wire logic                           read_ok_i,
  input  wire logic                           take_i,
  output bcs_batch_t                          batch_o,
  output bcs_result_t [MaxResults-1:0]        results_o
);

  localparam logic [5:0] MS_MAX = 6'd63;

  // Input register.
  logic        in_valid_q;
  logic [23:0] bytes_q;
  logic        ok_q;

  // Sequencer state.
  bcs_phase_e  phase_q, phase_d;
  bcs_wait_e   wait_q, wait_d;
  logic [5:0]  ms_q, ms_d;

  logic [5:0]  ms_inc;
  logic [4:0]  wait_ms;
  logic        fire;
  logic [1:0]  count;
  logic [7:0]  pres_cmd;
  logic [3:0]  pres_shift;
  logic [23:0] pres_raw;
  logic [18:0] temp_raw;

  assign tick_ready_o = !in_valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (tick_ready_o) begin
      in_valid_q <= tick_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_valid_i && tick_ready_o) begin
      bytes_q <= sensor_bytes_i;
      ok_q    <= read_ok_i;
    end
  end

  // Wait of the current phase and the action test.
  always_comb begin
    case (wait_q)
      WAIT_TEMP: wait_ms = TEMP_WAIT_MS;
      WAIT_PRES: wait_ms = bcs_pres_wait(cfg_i.oversampling);
      default:   wait_ms = '0;
    endcase
  end

  assign ms_inc = (ms_q == MS_MAX) ? ms_q : ms_q + 6'd1;
  assign fire   = cfg_i.enable && (ms_inc > {1'b0, wait_ms});

  // Next state.
  always_comb begin
    phase_d = phase_q;
    wait_d  = wait_q;
    ms_d    = ms_q;
    if (cfg_i.enable) begin
      ms_d = fire ? '0 : ms_inc;
    end
    if (fire) begin
      unique case (phase_q) inside
        PH_START_TEMP: begin
          phase_d = PH_READ_TEMP;
          wait_d  = WAIT_TEMP;
        end
        PH_READ_TEMP, PH_START_PRES: begin
          phase_d = PH_READ_PRES;
          wait_d  = WAIT_PRES;
        end
        PH_READ_PRES: begin
          phase_d = PH_START_TEMP;
          wait_d  = WAIT_NONE;
        end
        default: phase_d = phase_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START_TEMP;
      wait_q  <= WAIT_PRES;
      ms_q    <= '0;
    end else if (take_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      ms_q    <= ms_d;
    end
  end

  // Sample shaping and the pressure control byte.
  assign pres_cmd   = CMD_PRES_START + {cfg_i.oversampling, 6'd0};
  assign pres_shift = 4'd8 - {2'd0, cfg_i.oversampling};
  assign pres_raw   = bytes_q >> pres_shift;
  assign temp_raw   = {3'd0, bytes_q[23:8]};

  // Result words of this tick.
  always_comb begin
    results_o = '0;
    count     = '0;
    if (fire) begin
      unique case (phase_q)
        PH_START_TEMP: begin
          results_o[0] = bcs_bus_write(CMD_TEMP_START);
          count        = 2'd1;
        end
        PH_READ_TEMP: begin
          results_o[0] = bcs_bus_read(TEMP_READ_LEN);
          if (ok_q) begin
            results_o[1] = bcs_sample(KIND_TEMP_SAMPLE, temp_raw);
            results_o[2] = bcs_bus_write(pres_cmd);
            count        = 2'd3;
          end else begin
            results_o[1] = bcs_bus_write(pres_cmd);
            count        = 2'd2;
          end
        end
        PH_START_PRES: begin
          results_o[0] = bcs_bus_write(pres_cmd);
          count        = 2'd1;
        end
        PH_READ_PRES: begin
          results_o[0] = bcs_bus_read(PRES_READ_LEN);
          if (ok_q) begin
            results_o[1] = bcs_sample(KIND_PRES_SAMPLE, pres_raw[18:0]);
            count        = 2'd2;
          end else begin
            count        = 2'd1;
          end
        end
        default: count = '0;
      endcase
    end
    // Mark the final word of the tick.
    for (int i = 0; i < MaxResults; i++) begin
      results_o[i].last = (count == 2'(i + 1));
    end
  end

  assign batch_o.valid = in_valid_q;
  assign batch_o.count = count;

  // The counter restarts after every action.
  `BCS_ASSERT_NEXT(a_ms_cleared, clk_i, rst_ni, take_i && fire, ms_q == '0,
                   "counter not cleared after action")
  // A disabled sequencer keeps its phase.
  `BCS_ASSERT_NEXT(a_disabled_hold, clk_i, rst_ni, take_i && !cfg_i.enable, $stable(phase_q),
                   "phase moved while disabled")

endmodule

`default_nettype wire

// ===== sv/bcs_out_buf.sv =====
`default_nettype none

`include "assert_macros.svh"

module bcs_out_buf
  import bcs_pkg::*;
(
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bcs_batch_t                     batch_i,
  input  wire bcs_result_t [MaxResults-1:0]   results_i,
  output logic                                take_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output bcs_result_t                         out_word_o
);

  bcs_result_t [MaxResults-1:0] slots_q;
  logic [1:0]                   left_q;
  logic [1:0]                   idx_q;
  logic                         out_fire;

  assign out_valid_o = (left_q != 2'd0);
  assign out_fire    = out_valid_o && out_ready_i;

  // Load a new tick once the last pending word leaves.
  assign take_o = batch_i.valid && ((left_q == 2'd0) || ((left_q == 2'd1) && out_ready_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      idx_q  <= '0;
    end else if (take_o) begin
      left_q <= batch_i.count;
      idx_q  <= '0;
    end else if (out_fire) begin
      left_q <= left_q - 2'd1;
      idx_q  <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      slots_q <= results_i;
    end
  end

  assign out_word_o = slots_q[idx_q];

  // The word on the port carries last exactly when it is the tick's final one.
  `BCS_ASSERT_IMPL(a_last_match, clk_i, rst_ni, out_valid_o, out_word_o.last == (left_q == 2'd1), "last flag out of step")
  // No pending word is overwritten by a load.
  `BCS_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, take_o, (left_q == 2'd0) || ((left_q == 2'd1) && out_fire), "load over pending words")

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top
  import bcs_pkg::*;
();

  // Register indexes; each register sits at byte address 4 * index.
  localparam int unsigned REG_OVERSAMPLING = 0;
  localparam int unsigned REG_ENABLE       = 1;

  // Cycles allowed for a tick that produces no word to leave the pipeline.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;   // [23:0] sensor_bytes
  logic        s_axis_tuser  = 1'b0; // [0] read_ok

  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [39:0] m_axis_tdata;         // [7:0] reg_addr, [15:8] write_byte,
                                     // [17:16] read_len, [36:18] sample, [39:37] zero
  logic [1:0]  m_axis_tuser;         // [1:0] kind
  logic        m_axis_tlast;

  barometer_conversion_sequencer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 2 ns clock.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Sequencer model state and its copy of the registers.
  bcs_phase_e  seq_phase    = PH_START_TEMP;
  bcs_wait_e   seq_wait     = WAIT_PRES;
  logic [5:0]  ms_count     = '0;
  logic [1:0]  cfg_oss      = 2'd2;
  logic        cfg_enable   = 1'b1;

  bcs_result_t expected_words[$];
  bcs_result_t head_word;
  int          error_count   = 0;
  int          words_checked = 0;
  int          ticks_sent    = 0;
  int          cycle_count   = 0;
  logic        idle_on       = 1'b1;
  int          stall_left    = 0;

  // Pressure conversion time in milliseconds for each oversampling setting.
  function automatic logic [5:0] pres_wait_ms(input logic [1:0] oss);
    case (oss)
      2'd0:    return 6'd5;
      2'd1:    return 6'd8;
      2'd2:    return 6'd14;
      default: return 6'd26;
    endcase
  endfunction

  function automatic bcs_result_t make_word(input bcs_kind_e k, input logic [7:0] addr,
                                            input logic [7:0] wbyte, input logic [1:0] len,
                                            input logic [18:0] smp);
    bcs_result_t r;
    r.kind       = k;
    r.reg_addr   = addr;
    r.write_byte = wbyte;
    r.read_len   = len;
    r.sample     = smp;
    r.last       = 1'b0;
    return r;
  endfunction

  // Advances the sequencer model by one millisecond tick and queues its words.
  task automatic predict_tick(input logic [23:0] bytes, input logic ok);
    bcs_result_t w [3];
    int          n;
    logic [5:0]  wait_ms;
    logic [7:0]  pres_cmd;
    logic [23:0] pres_raw;
    n = 0;
    if (!cfg_enable) return;
    if (ms_count != 6'd63) ms_count = ms_count + 6'd1;
    case (seq_wait)
      WAIT_TEMP: wait_ms = 6'(TEMP_WAIT_MS);
      WAIT_PRES: wait_ms = pres_wait_ms(cfg_oss);
      default:   wait_ms = 6'd0;
    endcase
    if (ms_count <= wait_ms) return;
    pres_cmd = CMD_PRES_START + {cfg_oss, 6'b0};
    pres_raw = bytes >> (4'd8 - {2'b00, cfg_oss});
    case (seq_phase)
      PH_START_TEMP: begin
        w[n] = make_word(KIND_BUS_WRITE, SENSOR_REG_CTRL, CMD_TEMP_START, 2'd0, '0);
        n++;
        seq_phase = PH_READ_TEMP;
        seq_wait  = WAIT_TEMP;
      end
      PH_READ_TEMP: begin
        w[n] = make_word(KIND_BUS_READ, SENSOR_REG_DATA, 8'h00, TEMP_READ_LEN, '0);
        n++;
        if (ok) begin
          w[n] = make_word(KIND_TEMP_SAMPLE, 8'h00, 8'h00, 2'd0, {3'b000, bytes[23:8]});
          n++;
        end
        // The pressure conversion starts in the same tick.
        w[n] = make_word(KIND_BUS_WRITE, SENSOR_REG_CTRL, pres_cmd, 2'd0, '0);
        n++;
        seq_phase = PH_READ_PRES;
        seq_wait  = WAIT_PRES;
      end
      PH_START_PRES: begin
        w[n] = make_word(KIND_BUS_WRITE, SENSOR_REG_CTRL, pres_cmd, 2'd0, '0);
        n++;
        seq_phase = PH_READ_PRES;
        seq_wait  = WAIT_PRES;
      end
      default: begin
        w[n] = make_word(KIND_BUS_READ, SENSOR_REG_DATA, 8'h00, PRES_READ_LEN, '0);
        n++;
        if (ok) begin
          w[n] = make_word(KIND_PRES_SAMPLE, 8'h00, 8'h00, 2'd0, pres_raw[18:0]);
          n++;
        end
        seq_phase = PH_START_TEMP;
        seq_wait  = WAIT_NONE;
      end
    endcase
    ms_count = 6'd0;
    w[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_words.push_back(w[i]);
  endtask

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Compares every accepted result word with the oldest predicted one.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual kind %0h data %0h last %0b",
                 $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        head_word = expected_words.pop_front();
        check_field("kind", 32'(head_word.kind), 32'(m_axis_tuser));
        check_field("reg_addr", 32'(head_word.reg_addr), 32'(m_axis_tdata[7:0]));
        check_field("write_byte", 32'(head_word.write_byte), 32'(m_axis_tdata[15:8]));
        check_field("read_len", 32'(head_word.read_len), 32'(m_axis_tdata[17:16]));
        check_field("sample", 32'(head_word.sample), 32'(m_axis_tdata[36:18]));
        check_field("padding", 32'd0, 32'(m_axis_tdata[39:37]));
        check_field("last", 32'(head_word.last), 32'(m_axis_tlast));
        words_checked++;
      end
    end
  end

  // Result stream back-pressure in random bursts while idling is on.
  always @(posedge clk_i) begin
    if (!idle_on) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words still expected", $time, expected_words.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] exp_v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field($sformatf("register at %0h", addr), exp_v, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops the tick stream and lets every outstanding word drain.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input int unsigned idx, input logic [31:0] value);
    logic [2:0] addr;
    addr = 3'(4 * idx);
    wait_idle();
    apb_write(addr, value);
    if (idx == REG_OVERSAMPLING) begin
      cfg_oss = value[1:0];
      apb_read_check(addr, {30'b0, cfg_oss});
    end else begin
      cfg_enable = value[0];
      apb_read_check(addr, {31'b0, cfg_enable});
    end
  endtask

  // Sends one tick word, with an occasional random gap before it.
  task automatic send_tick(input logic [23:0] bytes, input logic ok);
    if (idle_on && ($urandom_range(0, 3) == 0)) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= bytes;
    s_axis_tuser  <= ok;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_tick(bytes, ok);
    ticks_sent++;
  endtask

  // Reset values, then both extremes of the oversampling register and enable set to one.
  task automatic test_register_access();
    apb_read_check(3'(4 * REG_OVERSAMPLING), 32'd2);
    apb_read_check(3'(4 * REG_ENABLE), 32'd1);
    write_register(REG_OVERSAMPLING, 32'd3);
    write_register(REG_OVERSAMPLING, 32'd0);
    write_register(REG_ENABLE, 32'd1);
  endtask

  // One full pass through the loop at the shortest waits with full-scale bytes and
  // good reads, then the temperature steps again with zero bytes and failed reads.
  task automatic test_directed_ticks();
    write_register(REG_OVERSAMPLING, 32'd0);
    for (int i = 1; i <= 25; i++) begin
      if (i <= 18) send_tick(24'hFFFFFF, 1'b1);
      else send_tick(24'h000000, 1'b0);
    end
  endtask

  // Ticks while disabled must change nothing, even in the middle of a wait.
  task automatic test_disabled_ticks();
    write_register(REG_ENABLE, 32'd0);
    for (int i = 0; i < 6; i++) send_tick(24'($urandom()), 1'($urandom()));
    write_register(REG_ENABLE, 32'd1);
  endtask

  task automatic test_random_ticks(input logic [1:0] oss, input int n_ticks);
    write_register(REG_OVERSAMPLING, {30'b0, oss});
    for (int i = 0; i < n_ticks; i++) begin
      send_tick(24'($urandom()), $urandom_range(0, 4) != 0);
    end
  endtask

  // Back-to-back ticks with the result stream always ready.
  task automatic test_full_rate(input int n_ticks);
    write_register(REG_OVERSAMPLING, 32'd2);
    idle_on <= 1'b0;
    for (int i = 0; i < n_ticks; i++) begin
      send_tick(24'($urandom()), $urandom_range(0, 4) != 0);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_directed_ticks();
    test_disabled_ticks();
    test_random_ticks(2'd3, 90);
    test_random_ticks(2'd0, 90);
    test_random_ticks(2'd1, 90);
    test_random_ticks(2'd2, 90);
    test_full_rate(80);
    wait_idle();
    $display("Sent %0d ticks and checked %0d result words across all oversampling settings,",
             ticks_sent, words_checked);
    $display("with enable toggled, failed reads, and random gaps and stalls on both streams.");
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
